[design/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg: shared definitions for the text console writer
// Screen geometry, field widths, command codes, FSM states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int SCREEN_COLS = 80;
    localparam int SCREEN_ROWS = 25;
    localparam int CELL_COUNT  = SCREEN_ROWS * SCREEN_COLS;

    // internal widths
    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int CNT_W  = $clog2(CELL_COUNT + 1);
    localparam int ROW_W  = $clog2(SCREEN_ROWS + 1);
    localparam int COL_W  = $clog2(SCREEN_COLS + 1);

    // port field widths
    localparam int MODE_W     = 2;
    localparam int BYTE_W     = 8;
    localparam int INDEX_W    = 11;
    localparam int ROW_PORT_W = 5;
    localparam int COL_PORT_W = 7;
    localparam int CELL_W     = 16;

    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0020;

    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR   = 2'd0,
        MODE_PUT     = 2'd1,
        MODE_NEWLINE = 2'd2,
        MODE_READ    = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_PREP,
        S_SCROLL,
        S_WRITE,
        S_NEWLINE,
        S_READ,
        S_RESP
    } t_state;

    typedef struct packed {
        logic capture;     // latch request fields, restart sweep counter
        logic fill;        // write one blank cell, advance counter
        logic home;        // cursor to row 0, column 0
        logic prep;        // column wrap and scroll decision
        logic scroll;      // one step of the scroll copy sweep
        logic write_cell;  // store character at cursor, advance column
        logic newline;     // next row if column nonzero
        logic read_cell;   // read cell at requested index
        logic load_out;    // load result register
    } t_cmd;

    typedef struct packed {
        logic fill_last;
        logic scroll_last;
        logic need_scroll;
        logic out_free;
    } t_status;

endpackage

[design/tcw_ctrl.sv]
// ----------------------------------------------------------------------------
// tcw_ctrl: sequencing state machine
// Steps each request through its states and drives datapath commands.
// ----------------------------------------------------------------------------
module tcw_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic [tcw_pkg::MODE_W-1:0]  i_mode,
    input  tcw_pkg::t_status            i_status,
    output tcw_pkg::t_cmd               o_cmd,
    output logic                        o_in_ready
);
    import tcw_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_INIT: begin
                o_cmd.fill = 1'b1;
                if (i_status.fill_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    case (t_mode'(i_mode))
                        MODE_CLEAR:   n_state = S_CLEAR;
                        MODE_PUT:     n_state = S_PREP;
                        MODE_NEWLINE: n_state = S_NEWLINE;
                        MODE_READ:    n_state = S_READ;
                        default:      n_state = S_IDLE;
                    endcase
                end
            end
            S_CLEAR: begin
                o_cmd.fill = 1'b1;
                if (i_status.fill_last) begin
                    o_cmd.home = 1'b1;
                    n_state    = S_RESP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = i_status.need_scroll ? S_SCROLL : S_WRITE;
            end
            S_SCROLL: begin
                o_cmd.scroll = 1'b1;
                if (i_status.scroll_last) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.write_cell = 1'b1;
                n_state          = S_RESP;
            end
            S_NEWLINE: begin
                o_cmd.newline = 1'b1;
                n_state       = S_RESP;
            end
            S_READ: begin
                o_cmd.read_cell = 1'b1;
                n_state         = S_RESP;
            end
            S_RESP: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

endmodule

[design/tcw_datapath.sv]
// ----------------------------------------------------------------------------
// tcw_datapath: cell store, cursor and result register
// One-write/one-read cell memory, sweep counter, cursor math, output stage.
// ----------------------------------------------------------------------------
module tcw_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tcw_pkg::t_cmd                   i_cmd,
    output tcw_pkg::t_status                o_status,
    input  logic [tcw_pkg::MODE_W-1:0]      i_mode,
    input  logic [tcw_pkg::BYTE_W-1:0]      i_char_code,
    input  logic [tcw_pkg::BYTE_W-1:0]      i_color,
    input  logic [tcw_pkg::INDEX_W-1:0]     i_cell_index,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [tcw_pkg::ROW_PORT_W-1:0]  o_cursor_row,
    output logic [tcw_pkg::COL_PORT_W-1:0]  o_cursor_column,
    output logic [tcw_pkg::CELL_W-1:0]      o_cell_data,
    output logic                            o_scrolled
);
    import tcw_pkg::*;

    logic [CELL_W-1:0] r_cells [CELL_COUNT];

    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_scrolled;
    logic              r_is_read;
    logic              r_idx_ok;
    logic [ADDR_W-1:0] r_idx;
    logic [BYTE_W-1:0] r_char;
    logic [BYTE_W-1:0] r_color;
    logic [CELL_W-1:0] r_rdata;

    logic                  r_out_valid;
    logic [ROW_PORT_W-1:0] r_out_row;
    logic [COL_PORT_W-1:0] r_out_col;
    logic [CELL_W-1:0]     r_out_data;
    logic                  r_out_scrolled;

    logic              wrap;
    logic [ROW_W:0]    row_w;
    logic              need_scroll;
    logic [ADDR_W-1:0] put_addr;
    logic              scroll_rd_ok;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CELL_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    // cursor wrap and scroll decision for a put
    always_comb begin
        wrap        = 32'(r_col) >= SCREEN_COLS;
        row_w       = {1'b0, r_row} + (ROW_W+1)'(wrap);
        need_scroll = 32'(row_w) >= SCREEN_ROWS;
        put_addr    = ADDR_W'(r_row) * ADDR_W'(SCREEN_COLS) + ADDR_W'(r_col);
    end

    // scroll sweep: read cell k+COLS, write cell k-1 from previous read
    assign scroll_rd_ok = 32'(r_cnt) < (CELL_COUNT - SCREEN_COLS);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = ADDR_W'(r_cnt);
        wr_data = BLANK_CELL;
        if (i_cmd.fill) begin
            wr_en = 1'b1;
        end else if (i_cmd.scroll) begin
            wr_en   = r_cnt != '0;
            wr_addr = ADDR_W'(r_cnt - CNT_W'(1));
            wr_data = (32'(r_cnt) <= (CELL_COUNT - SCREEN_COLS)) ? r_rdata : BLANK_CELL;
        end else if (i_cmd.write_cell) begin
            wr_en   = 1'b1;
            wr_addr = put_addr;
            wr_data = {r_color, r_char};
        end
    end

    always_comb begin
        rd_en   = i_cmd.read_cell || (i_cmd.scroll && scroll_rd_ok);
        rd_addr = i_cmd.scroll ? ADDR_W'(r_cnt + CNT_W'(SCREEN_COLS)) : r_idx;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_cells[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_cells[rd_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_col       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_cnt <= '0;
            end else if (i_cmd.fill || i_cmd.scroll) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end

            if (i_cmd.home) begin
                r_row <= '0;
                r_col <= '0;
            end else if (i_cmd.prep) begin
                r_row <= need_scroll ? ROW_W'(SCREEN_ROWS - 1) : row_w[ROW_W-1:0];
                r_col <= wrap ? '0 : r_col;
            end else if (i_cmd.write_cell) begin
                r_col <= r_col + COL_W'(1);
            end else if (i_cmd.newline && (r_col != '0)) begin
                r_row <= r_row + ROW_W'(1);
                r_col <= '0;
            end

            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request fields and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_char     <= i_char_code;
            r_color    <= i_color;
            r_idx      <= ADDR_W'(i_cell_index);
            r_idx_ok   <= 32'(i_cell_index) < CELL_COUNT;
            r_is_read  <= t_mode'(i_mode) == MODE_READ;
            r_scrolled <= 1'b0;
        end else if (i_cmd.prep && need_scroll) begin
            r_scrolled <= 1'b1;
        end
        if (i_cmd.load_out) begin
            r_out_row      <= ROW_PORT_W'(r_row);
            r_out_col      <= COL_PORT_W'(r_col);
            r_out_data     <= (r_is_read && r_idx_ok) ? r_rdata : '0;
            r_out_scrolled <= r_scrolled;
        end
    end

    always_comb begin
        o_status.fill_last   = r_cnt == CNT_W'(CELL_COUNT - 1);
        o_status.scroll_last = r_cnt == CNT_W'(CELL_COUNT);
        o_status.need_scroll = need_scroll;
        o_status.out_free    = !r_out_valid || i_out_ready;
    end

    assign o_out_valid     = r_out_valid;
    assign o_cursor_row    = r_out_row;
    assign o_cursor_column = r_out_col;
    assign o_cell_data     = r_out_data;
    assign o_scrolled      = r_out_scrolled;

endmodule

[design/text_console_writer.sv]
// ----------------------------------------------------------------------------
// text_console_writer: 25x80 character-cell screen writer, one request at a time
// A clear and a scrolling put each sweep the single-write-port store cell by cell.
// The next request is taken the cycle after the result loads, not while one is in work.
// Reset: cursor homed, then a blanking pass over every cell with in_ready low.
// ----------------------------------------------------------------------------
module text_console_writer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [tcw_pkg::MODE_W-1:0]      i_mode,
    input  logic [tcw_pkg::BYTE_W-1:0]      i_char_code,
    input  logic [tcw_pkg::BYTE_W-1:0]      i_color,
    input  logic [tcw_pkg::INDEX_W-1:0]     i_cell_index,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [tcw_pkg::ROW_PORT_W-1:0]  o_cursor_row,
    output logic [tcw_pkg::COL_PORT_W-1:0]  o_cursor_column,
    output logic [tcw_pkg::CELL_W-1:0]      o_cell_data,
    output logic                            o_scrolled
);
    import tcw_pkg::*;

    // Controller owns sequencing; datapath owns the cell store, cursor and
    // the result register. A finished result parks in the result register,
    // so the next request is taken while the previous result waits.
    t_cmd    cmd;
    t_status status;

    // Request flow per mode:
    //   clear   - sweep blank into every cell, home cursor
    //   put     - wrap column, optional scroll sweep (copy rows up, blank
    //             bottom row), write cell, advance column
    //   newline - next row if column nonzero; scroll waits for next put
    //   read    - registered read of one cell, zero when out of range
    tcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_ready (o_in_ready)
    );

    tcw_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_mode          (i_mode),
        .i_char_code     (i_char_code),
        .i_color         (i_color),
        .i_cell_index    (i_cell_index),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_cursor_row    (o_cursor_row),
        .o_cursor_column (o_cursor_column),
        .o_cell_data     (o_cell_data),
        .o_scrolled      (o_scrolled)
    );

`ifndef ASSERT_OFF
    // one request in flight: taking a request closes the input side
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted while previous one still in work");

    // a result is never loaded over one that has not been taken
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> status.out_free)
        else $error("result register overwritten");

    // a scrolling put leaves the cursor on the bottom row
    a_scroll_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_scrolled) |->
            (o_cursor_row == ROW_PORT_W'(SCREEN_ROWS - 1)))
        else $error("scroll left cursor off bottom row");

    // column never passes the wrap-pending value
    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_cursor_column) <= SCREEN_COLS))
        else $error("cursor column out of range");
`endif

endmodule
